### rtl/ipv4hv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4hv_pkg
// types and constants for the ipv4 header validator: frame offsets,
// verdict and drop reason codes
// ----------------------------------------------------------------------------
package ipv4hv_pkg;

    localparam int CountW = 17;

    typedef logic [CountW-1:0] t_count;
    typedef logic [3:0]        t_reason;
    typedef logic [1:0]        t_verdict;

    localparam t_count COUNT_MAX     = '1;
    localparam t_count POS_ETYPE_HI  = 17'd12;
    localparam t_count POS_ETYPE_LO  = 17'd13;
    localparam t_count POS_HDR_START = 17'd14;
    localparam t_count POS_TLEN_HI   = 17'd16;
    localparam t_count POS_TLEN_LO   = 17'd17;
    localparam t_count POS_FRAG_HI   = 17'd20;
    localparam t_count POS_FRAG_LO   = 17'd21;
    localparam t_count POS_PROTO     = 17'd23;
    localparam t_count POS_DEST_HI   = 17'd30;
    localparam t_count POS_HDR_END   = 17'd33;
    localparam t_count MIN_FRAME     = 17'd34;

    localparam logic [7:0]  IP_VER_HDRLEN = 8'h45;
    localparam logic [15:0] ETYPE_IPV4   = 16'h0800;
    localparam logic [15:0] MIN_TLEN     = 16'd20;
    localparam logic [15:0] SUM_GOOD     = 16'hFFFF;
    localparam logic [7:0]  PROTO_UDP    = 8'd17;
    localparam logic [7:0]  PROTO_ICMP   = 8'd1;

    localparam t_verdict VERDICT_DROP = 2'd0;
    localparam t_verdict VERDICT_UDP  = 2'd1;
    localparam t_verdict VERDICT_ICMP = 2'd2;

    localparam t_reason REASON_NONE     = 4'd0;
    localparam t_reason REASON_SHORT    = 4'd1;
    localparam t_reason REASON_ETYPE    = 4'd2;
    localparam t_reason REASON_VERSION  = 4'd3;
    localparam t_reason REASON_ADDRESS  = 4'd4;
    localparam t_reason REASON_FRAGMENT = 4'd5;
    localparam t_reason REASON_LENGTH   = 4'd6;
    localparam t_reason REASON_CHECKSUM = 4'd7;
    localparam t_reason REASON_PROTOCOL = 4'd8;

    // keep the highest priority (lowest nonzero) failure
    function automatic t_reason note_failure(t_reason cur, t_reason code);
        if (cur == REASON_NONE || code < cur) begin
            return code;
        end
        return cur;
    endfunction

endpackage

### rtl/ipv4_header_validator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_header_validator_top
// checks the ipv4 header of an ethernet frame, one byte per word, and gives
// one verdict with a drop reason on the final byte of each frame
// ----------------------------------------------------------------------------
// output: o_valid is registered; the final byte goes through the input
//   register, then the result register, and waits while the result is held
// throughput: one byte per cycle unless a final byte stalls behind a held
//   result; set by the single compare/add step on the input register
// reset: synchronous active low, clears the address register, frame state
//   and both pipeline stages
module ipv4_header_validator_top
    import ipv4hv_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_frame_byte,
    input  logic        i_frame_end,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_verdict,
    output logic [3:0]  o_drop_reason,
    output logic [15:0] o_ip_total_length
);

    logic [31:0] r_server_address;

    logic        r_s1_valid;
    logic [7:0]  r_s1_byte;
    logic        r_s1_end;

    t_count      r_count,  n_count;
    logic [15:0] r_sum,    n_sum;
    logic [7:0]  r_held,   n_held;
    t_reason     r_fail,   n_fail;
    logic [15:0] r_tlen,   n_tlen;
    logic [7:0]  r_proto,  n_proto;
    logic [7:0]  r_etype_hi, n_etype_hi;
    logic [7:0]  r_frag_hi,  n_frag_hi;
    logic [23:0] r_dest,   n_dest;

    logic        r_out_valid;
    t_verdict    r_verdict, n_verdict;
    t_reason     r_reason,  n_reason;
    logic [15:0] r_out_tlen;

    logic        s1_move;
    logic        in_accept;
    logic        out_take;
    logic        s1_fire;
    logic [16:0] word_sum;
    logic [15:0] folded_sum;
    logic [16:0] tlen_end;

    assign out_take  = r_out_valid && !i_stall;
    assign s1_move   = !r_s1_end || !r_out_valid || !i_stall;
    assign o_stall   = r_s1_valid && !s1_move;
    assign in_accept = i_valid && !o_stall;
    assign s1_fire   = r_s1_valid && s1_move;

    assign word_sum   = {1'b0, r_sum} + {1'b0, r_held, r_s1_byte};
    assign folded_sum = word_sum[15:0] + {15'd0, word_sum[16]};
    assign tlen_end   = {1'b0, n_tlen} + POS_HDR_START;

    // per-byte header state update
    always_comb begin
        n_count    = (r_count != COUNT_MAX) ? r_count + 17'd1 : r_count;
        n_sum      = r_sum;
        n_held     = r_held;
        n_fail     = r_fail;
        n_tlen     = r_tlen;
        n_proto    = r_proto;
        n_etype_hi = r_etype_hi;
        n_frag_hi  = r_frag_hi;
        n_dest     = r_dest;

        if (r_count == POS_ETYPE_HI) begin
            n_etype_hi = r_s1_byte;
        end
        if (r_count == POS_ETYPE_LO && {r_etype_hi, r_s1_byte} != ETYPE_IPV4) begin
            n_fail = note_failure(n_fail, REASON_ETYPE);
        end
        if (r_count == POS_HDR_START && r_s1_byte != IP_VER_HDRLEN) begin
            n_fail = note_failure(n_fail, REASON_VERSION);
        end
        if (r_count == POS_TLEN_HI) begin
            n_tlen = {r_s1_byte, 8'd0};
        end
        if (r_count == POS_TLEN_LO) begin
            n_tlen = {r_tlen[15:8], r_s1_byte};
            if ({r_tlen[15:8], r_s1_byte} < MIN_TLEN) begin
                n_fail = note_failure(n_fail, REASON_LENGTH);
            end
        end
        if (r_count == POS_FRAG_HI) begin
            n_frag_hi = r_s1_byte;
        end
        if (r_count == POS_FRAG_LO && (r_frag_hi[5:0] != 6'd0 || r_s1_byte != 8'd0)) begin
            n_fail = note_failure(n_fail, REASON_FRAGMENT);
        end
        if (r_count == POS_PROTO) begin
            n_proto = r_s1_byte;
            if (r_s1_byte != PROTO_UDP && r_s1_byte != PROTO_ICMP) begin
                n_fail = note_failure(n_fail, REASON_PROTOCOL);
            end
        end
        if (r_count >= POS_DEST_HI && r_count < POS_HDR_END) begin
            n_dest = {r_dest[15:0], r_s1_byte};
        end
        if (r_count >= POS_HDR_START && r_count <= POS_HDR_END) begin
            if (r_count[0] == 1'b0) begin
                n_held = r_s1_byte;
            end else begin
                n_sum = folded_sum;
            end
        end
        if (r_count == POS_HDR_END) begin
            if ({r_dest, r_s1_byte} != r_server_address) begin
                n_fail = note_failure(n_fail, REASON_ADDRESS);
            end
            if (folded_sum != SUM_GOOD) begin
                n_fail = note_failure(n_fail, REASON_CHECKSUM);
            end
        end
    end

    // verdict on the final byte
    always_comb begin
        if (n_count < MIN_FRAME) begin
            n_reason = REASON_SHORT;
        end else begin
            n_reason = n_fail;
            if (tlen_end > n_count && (n_fail == REASON_NONE || n_fail > REASON_LENGTH)) begin
                n_reason = REASON_LENGTH;
            end
        end
        if (n_reason != REASON_NONE) begin
            n_verdict = VERDICT_DROP;
        end else if (n_proto == PROTO_UDP) begin
            n_verdict = VERDICT_UDP;
        end else begin
            n_verdict = VERDICT_ICMP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_server_address <= '0;
        end else if (i_cfg_we) begin
            r_server_address <= i_cfg_wdata;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_end   <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
            r_s1_end   <= i_frame_end;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_byte <= i_frame_byte;
        end
    end

    // frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (s1_fire && r_s1_end)) begin
            r_count    <= '0;
            r_sum      <= '0;
            r_held     <= '0;
            r_fail     <= REASON_NONE;
            r_tlen     <= '0;
            r_proto    <= '0;
            r_etype_hi <= '0;
            r_frag_hi  <= '0;
            r_dest     <= '0;
        end else if (s1_fire) begin
            r_count    <= n_count;
            r_sum      <= n_sum;
            r_held     <= n_held;
            r_fail     <= n_fail;
            r_tlen     <= n_tlen;
            r_proto    <= n_proto;
            r_etype_hi <= n_etype_hi;
            r_frag_hi  <= n_frag_hi;
            r_dest     <= n_dest;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire && r_s1_end) begin
            r_out_valid <= 1'b1;
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && r_s1_end) begin
            r_verdict  <= n_verdict;
            r_reason   <= n_reason;
            r_out_tlen <= n_tlen;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_verdict         = r_verdict;
    assign o_drop_reason     = r_reason;
    assign o_ip_total_length = r_out_tlen;

    a_pass_no_reason : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_verdict != VERDICT_DROP) |-> (r_reason == REASON_NONE))
        else $error("pass verdict with a drop reason");

    a_drop_has_reason : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_verdict == VERDICT_DROP) |-> (r_reason != REASON_NONE))
        else $error("drop verdict without a reason");

    a_stall_only_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_s1_valid && r_s1_end && r_out_valid))
        else $error("input stalled with room in the pipeline");

    a_frame_cleared : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && r_s1_end) |=> (r_count == '0 && r_fail == REASON_NONE))
        else $error("frame state not cleared after final byte");

endmodule

### tb/sv/ipv4_header_validator_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_header_validator_top_tb
// self-checking bench for the ipv4 header validator: ethernet frames are
// built with correct or broken headers and fed one byte per word. A local
// model of the header checks predicts the verdict, drop reason and total
// length of every frame, and each result word is compared in order. Both
// handshakes idle at random; one long receiver hold fills the block.
// ----------------------------------------------------------------------------
module ipv4_header_validator_top_tb;
    import ipv4hv_pkg::*;

    localparam int  CYCLE_NS     = 12;
    localparam int  LIMIT_CYCLES = 1500000;
    localparam int  SETTLE       = 6;
    localparam int  HOLD_CYCLES  = 300;
    localparam int  ITEM_TARGET  = 950;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_frame_word;

    typedef struct packed {
        t_verdict    verdict;
        t_reason     reason;
        logic [15:0] tlen;
    } t_result;

    typedef struct {
        logic [15:0] etype;
        logic [7:0]  ver_ihl;
        logic [15:0] tlen;
        logic [15:0] frag;
        logic [7:0]  proto;
        logic [31:0] dst;
        logic [15:0] sum_err;
        int          body;
        int          cut;
    } t_frame;

    typedef enum int {
        D_SHORT, D_ETYPE, D_VERSION, D_ADDRESS, D_FRAGMENT,
        D_TLEN_LOW, D_TLEN_HIGH, D_CHECKSUM, D_PROTOCOL, D_TRUNCATE
    } t_defect;

    typedef enum int {RAW_RANDOM, RAW_ZEROS, RAW_ONES} t_raw_fill;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [31:0] i_cfg_wdata = '0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_frame_byte = '0;
    logic        i_frame_end = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [1:0]  o_verdict;
    logic [3:0]  o_drop_reason;
    logic [15:0] o_ip_total_length;

    ipv4_header_validator_top u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_frame_byte      (i_frame_byte),
        .i_frame_end       (i_frame_end),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_verdict         (o_verdict),
        .o_drop_reason     (o_drop_reason),
        .o_ip_total_length (o_ip_total_length)
    );

    always begin
        #(CYCLE_NS / 2) i_clk = 1'b1;
        #(CYCLE_NS / 2) i_clk = 1'b0;
    end

    t_frame_word pending_words[$];
    t_result     expected_verdicts[$];

    bit          rst_done = 1'b0;
    bit          tx_quiet = 1'b0;
    bit          rx_quiet = 1'b0;
    bit          byte_taken = 1'b0;
    int          tx_gap = 0;
    int          rx_gap = 0;
    int          hold_req = 0;
    int          hold_seen = 0;
    int          hold_left = 0;
    int          queued_count = 0;
    int          acc_count = 0;
    int          errors = 0;
    int          n_udp = 0;
    int          n_icmp = 0;
    int          n_drop = 0;
    int          in_stall_cycles = 0;
    int          addr_writes = 0;
    logic [15:0] reason_mask = '0;
    logic [31:0] cur_addr = '0;

    // predictor state
    logic [31:0] srv_addr = '0;
    t_count      hdr_count = '0;
    logic [15:0] hdr_sum = '0;
    logic [7:0]  hdr_hi = '0;
    t_reason     hdr_fail = REASON_NONE;
    logic [15:0] hdr_tlen = '0;
    logic [7:0]  hdr_proto = '0;
    logic [15:0] hdr_etype = '0;
    logic [15:0] hdr_frag = '0;
    logic [31:0] hdr_dest = '0;

    function automatic int pick_gap(input bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 65) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        if (r < 98) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic t_reason rank_failure(input t_reason cur, input t_reason code);
        return (cur == REASON_NONE || code < cur) ? code : cur;
    endfunction

    task automatic clear_frame_state();
        hdr_count = '0;
        hdr_sum   = '0;
        hdr_hi    = '0;
        hdr_fail  = REASON_NONE;
        hdr_tlen  = '0;
        hdr_proto = '0;
        hdr_etype = '0;
        hdr_frag  = '0;
        hdr_dest  = '0;
    endtask

    task automatic step_header(input logic [7:0] b, input logic last);
        t_count      pos;
        logic [16:0] s;
        t_reason     why;
        t_result     v;
        pos = hdr_count;
        if (pos == POS_ETYPE_HI) begin
            hdr_etype = {b, 8'h00};
        end
        if (pos == POS_ETYPE_LO) begin
            hdr_etype[7:0] = b;
            if (hdr_etype != ETYPE_IPV4) begin
                hdr_fail = rank_failure(hdr_fail, REASON_ETYPE);
            end
        end
        if (pos == POS_HDR_START && b != IP_VER_HDRLEN) begin
            hdr_fail = rank_failure(hdr_fail, REASON_VERSION);
        end
        if (pos == POS_TLEN_HI) begin
            hdr_tlen = {b, 8'h00};
        end
        if (pos == POS_TLEN_LO) begin
            hdr_tlen[7:0] = b;
            if (hdr_tlen < MIN_TLEN) begin
                hdr_fail = rank_failure(hdr_fail, REASON_LENGTH);
            end
        end
        if (pos == POS_FRAG_HI) begin
            hdr_frag = {b, 8'h00};
        end
        if (pos == POS_FRAG_LO) begin
            hdr_frag[7:0] = b;
            if ((hdr_frag & 16'h3FFF) != 16'h0000) begin
                hdr_fail = rank_failure(hdr_fail, REASON_FRAGMENT);
            end
        end
        if (pos == POS_PROTO) begin
            hdr_proto = b;
            if (b != PROTO_UDP && b != PROTO_ICMP) begin
                hdr_fail = rank_failure(hdr_fail, REASON_PROTOCOL);
            end
        end
        if (pos >= POS_DEST_HI && pos <= POS_HDR_END) begin
            hdr_dest = {hdr_dest[23:0], b};
        end
        if (pos >= POS_HDR_START && pos <= POS_HDR_END) begin
            if (pos[0] == 1'b0) begin
                hdr_hi = b;
            end else begin
                s = {1'b0, hdr_sum} + {1'b0, hdr_hi, b};
                hdr_sum = s[15:0] + {15'b0, s[16]};
            end
        end
        if (pos == POS_HDR_END) begin
            if (hdr_dest != srv_addr) begin
                hdr_fail = rank_failure(hdr_fail, REASON_ADDRESS);
            end
            if (hdr_sum != SUM_GOOD) begin
                hdr_fail = rank_failure(hdr_fail, REASON_CHECKSUM);
            end
        end
        if (hdr_count != COUNT_MAX) begin
            hdr_count = hdr_count + 1'b1;
        end
        if (last) begin
            if (hdr_count < MIN_FRAME) begin
                why = REASON_SHORT;
            end else begin
                why = hdr_fail;
                if ((18'(hdr_tlen) + 18'(POS_HDR_START)) > 18'(hdr_count) &&
                    (why == REASON_NONE || why > REASON_LENGTH)) begin
                    why = REASON_LENGTH;
                end
            end
            v.verdict = VERDICT_DROP;
            if (why == REASON_NONE) begin
                v.verdict = (hdr_proto == PROTO_UDP) ? VERDICT_UDP : VERDICT_ICMP;
            end
            v.reason = why;
            v.tlen   = hdr_tlen;
            expected_verdicts.push_back(v);
            clear_frame_state();
        end
    endtask

    // predictor and result checker
    always @(posedge i_clk) begin
        t_result exp_v;
        byte_taken <= i_rst_n && i_valid && !o_stall;
        if (!i_rst_n) begin
            srv_addr = '0;
            clear_frame_state();
        end else begin
            if (i_cfg_we) begin
                srv_addr = i_cfg_wdata;
            end
            if (i_valid && o_stall) begin
                in_stall_cycles++;
            end
            if (i_valid && !o_stall) begin
                acc_count++;
                step_header(i_frame_byte, i_frame_end);
            end
            if (o_valid && !i_stall) begin
                if (expected_verdicts.size() == 0) begin
                    $display("%0t: result word with nothing expected:", $time,
                             " verdict %0d reason %0d len %0d",
                             o_verdict, o_drop_reason, o_ip_total_length);
                    errors++;
                end else begin
                    exp_v = expected_verdicts.pop_front();
                    if ({o_verdict, o_drop_reason, o_ip_total_length} !== exp_v) begin
                        $display("%0t: mismatch expected verdict %0d reason %0d len %0d,",
                                 $time, exp_v.verdict, exp_v.reason, exp_v.tlen,
                                 " actual verdict %0d reason %0d len %0d",
                                 o_verdict, o_drop_reason, o_ip_total_length);
                        errors++;
                    end
                    case (exp_v.verdict)
                        VERDICT_UDP:  n_udp++;
                        VERDICT_ICMP: n_icmp++;
                        default:      n_drop++;
                    endcase
                    reason_mask[exp_v.reason] = 1'b1;
                end
            end
        end
    end

    // input driver
    always @(negedge i_clk) begin
        t_frame_word w;
        if (!rst_done) begin
            i_valid <= 1'b0;
        end else if (i_valid && !byte_taken) begin
            // stalled word stays put
        end else if (tx_gap > 0) begin
            i_valid <= 1'b0;
            tx_gap  <= tx_gap - 1;
        end else if (pending_words.size() > 0) begin
            w = pending_words.pop_front();
            i_frame_byte <= w.data;
            i_frame_end  <= w.last;
            i_valid      <= 1'b1;
            tx_gap       <= pick_gap(tx_quiet);
        end else begin
            i_valid <= 1'b0;
        end
    end

    // result receiver
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_seen != hold_req) begin
            i_stall   <= 1'b1;
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
        end else if (rx_gap > 0) begin
            i_stall <= 1'b1;
            rx_gap  <= rx_gap - 1;
        end else begin
            i_stall <= 1'b0;
            rx_gap  <= pick_gap(rx_quiet);
        end
    end

    task automatic push_word(input logic [7:0] data, input logic last);
        t_frame_word w;
        w.data = data;
        w.last = last;
        pending_words.push_back(w);
        queued_count++;
    endtask

    task automatic queue_frame(input t_frame f);
        logic [7:0]  hb[20];
        logic [16:0] s;
        logic [15:0] sum;
        logic [15:0] csum;
        int          len;
        logic [7:0]  d;
        hb[0] = f.ver_ihl;
        hb[1] = 8'($urandom_range(0, 255));
        hb[2] = f.tlen[15:8];
        hb[3] = f.tlen[7:0];
        hb[4] = 8'($urandom_range(0, 255));
        hb[5] = 8'($urandom_range(0, 255));
        hb[6] = f.frag[15:8];
        hb[7] = f.frag[7:0];
        hb[8] = 8'($urandom_range(0, 255));
        hb[9] = f.proto;
        hb[10] = 8'h00;
        hb[11] = 8'h00;
        for (int i = 12; i < 16; i++) begin
            hb[i] = 8'($urandom_range(0, 255));
        end
        for (int i = 0; i < 4; i++) begin
            hb[16 + i] = f.dst[31 - 8 * i -: 8];
        end
        sum = '0;
        for (int i = 0; i < 10; i++) begin
            s = {1'b0, sum} + {1'b0, hb[2 * i], hb[2 * i + 1]};
            sum = s[15:0] + {15'b0, s[16]};
        end
        csum = ~sum ^ f.sum_err;
        hb[10] = csum[15:8];
        hb[11] = csum[7:0];
        len = 34 + f.body;
        if (f.cut > 0 && f.cut < len) begin
            len = f.cut;
        end
        for (int i = 0; i < len; i++) begin
            if (i == 12) begin
                d = f.etype[15:8];
            end else if (i == 13) begin
                d = f.etype[7:0];
            end else if (i >= 14 && i < 34) begin
                d = hb[i - 14];
            end else begin
                d = 8'($urandom_range(0, 255));
            end
            push_word(d, i == len - 1);
        end
    endtask

    task automatic queue_raw(input int len, input t_raw_fill fill);
        logic [7:0] d;
        for (int i = 0; i < len; i++) begin
            case (fill)
                RAW_ZEROS: d = 8'h00;
                RAW_ONES:  d = 8'hFF;
                default:   d = 8'($urandom_range(0, 255));
            endcase
            push_word(d, i == len - 1);
        end
    endtask

    function automatic t_frame good_frame(input logic [7:0] proto, input int body);
        t_frame f;
        f.etype   = ETYPE_IPV4;
        f.ver_ihl = IP_VER_HDRLEN;
        f.tlen    = 16'(20 + body);
        f.frag    = $urandom_range(0, 1) ? 16'h4000 : 16'h0000;
        f.proto   = proto;
        f.dst     = cur_addr;
        f.sum_err = '0;
        f.body    = body;
        f.cut     = 0;
        return f;
    endfunction

    function automatic t_frame add_defect(input t_frame fin, input t_defect k);
        t_frame f;
        f = fin;
        case (k)
            D_SHORT:    f.cut = $urandom_range(1, 33);
            D_ETYPE:    f.etype = f.etype ^ 16'($urandom_range(1, 65535));
            D_VERSION:  f.ver_ihl = f.ver_ihl ^ 8'($urandom_range(1, 255));
            D_ADDRESS:  f.dst = f.dst ^ (32'h1 << $urandom_range(0, 31));
            D_FRAGMENT: f.frag = 16'($urandom_range(0, 65535)) | (16'h1 << $urandom_range(0, 13));
            D_TLEN_LOW: f.tlen = 16'($urandom_range(0, 19));
            D_TLEN_HIGH: begin
                if ($urandom_range(0, 1)) begin
                    f.tlen = 16'(20 + f.body + $urandom_range(1, 3));
                end else begin
                    f.tlen = 16'($urandom_range(21 + f.body, 65535));
                end
            end
            D_CHECKSUM: f.sum_err = 16'($urandom_range(1, 65535));
            D_PROTOCOL: begin
                do begin
                    f.proto = 8'($urandom_range(0, 255));
                end while (f.proto == PROTO_UDP || f.proto == PROTO_ICMP);
            end
            default:    f.cut = $urandom_range(34, 34 + f.body);
        endcase
        return f;
    endfunction

    function automatic int pick_body();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return $urandom_range(0, 12);
        end
        if (r < 95) begin
            return $urandom_range(13, 60);
        end
        return $urandom_range(61, 300);
    endfunction

    task automatic queue_random_frame();
        t_frame f;
        int     r;
        r = $urandom_range(0, 99);
        f = good_frame($urandom_range(0, 1) ? PROTO_UDP : PROTO_ICMP, pick_body());
        if (r < 10) begin
            queue_raw($urandom_range(1, 60), RAW_RANDOM);
            return;
        end
        if (r < 50) begin
            if ($urandom_range(0, 2) == 0) begin
                f.tlen = 16'(20 + $urandom_range(0, f.body));
            end
        end else begin
            f = add_defect(f, t_defect'($urandom_range(0, 9)));
            if ($urandom_range(0, 4) == 0) begin
                f = add_defect(f, t_defect'($urandom_range(0, 9)));
            end
        end
        queue_frame(f);
    endtask

    // wait until every word is in and every result is out, then let the pipe settle
    task automatic drain();
        @(negedge i_clk);
        while (acc_count != queued_count || expected_verdicts.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_addr(input logic [31:0] a);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= a;
        cur_addr = a;
        addr_writes++;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        t_frame      f;
        int          n;
        logic [31:0] a;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        rst_done = 1'b1;

        // directed frames against the reset address
        queue_frame(good_frame(PROTO_UDP, 8));
        queue_frame(good_frame(PROTO_ICMP, 0));
        f = good_frame(PROTO_UDP, 10);
        f.tlen = 16'd24;
        queue_frame(f);
        for (int k = 0; k < 10; k++) begin
            queue_frame(add_defect(good_frame(PROTO_UDP, 2), t_defect'(k)));
        end
        f = good_frame(PROTO_UDP, 0);
        f.cut = 1;
        queue_frame(f);
        f.cut = 33;
        queue_frame(f);
        f = good_frame(PROTO_ICMP, 0);
        f.tlen = 16'hFFFF;
        queue_frame(f);
        f = good_frame(PROTO_UDP, 0);
        f.frag = 16'h2000;
        queue_frame(f);
        f.frag = 16'h1FFF;
        queue_frame(f);
        f = add_defect(good_frame(PROTO_UDP, 0), D_ETYPE);
        queue_frame(add_defect(f, D_CHECKSUM));
        f = add_defect(good_frame(PROTO_ICMP, 0), D_PROTOCOL);
        queue_frame(add_defect(f, D_ADDRESS));
        queue_raw(34, RAW_ZEROS);
        queue_raw(40, RAW_ONES);

        // receiver holds off while the sender streams short frames
        drain();
        write_addr(32'hC0A8_0001);
        tx_quiet = 1'b1;
        hold_req++;
        for (int k = 0; k < 3; k++) begin
            queue_frame(good_frame($urandom_range(0, 1) ? PROTO_UDP : PROTO_ICMP,
                                   $urandom_range(0, 4)));
        end

        while (queued_count < ITEM_TARGET) begin
            drain();
            case ($urandom_range(0, 5))
                0:       a = 32'h0000_0000;
                1:       a = 32'hFFFF_FFFF;
                default: a = $urandom;
            endcase
            write_addr(a);
            tx_quiet = ($urandom_range(0, 5) == 0);
            rx_quiet = ($urandom_range(0, 5) == 0);
            n = $urandom_range(2, 3);
            for (int k = 0; k < n; k++) begin
                queue_random_frame();
            end
        end

        drain();
        $display("checked %0d frames: %0d udp, %0d icmp, %0d dropped, %0d words in",
                 n_udp + n_icmp + n_drop, n_udp, n_icmp, n_drop, acc_count);
        $display("drop reasons seen %b, %0d address settings, input stalled %0d cycles",
                 reason_mask[8:0], addr_writes, in_stall_cycles);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #(64'(CYCLE_NS) * LIMIT_CYCLES);
        $display("timeout with %0d results outstanding", expected_verdicts.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule

### filelist.f
rtl/ipv4hv_pkg.sv
rtl/ipv4_header_validator_top.sv
tb/sv/ipv4_header_validator_top_tb.sv
